// ----- hw/rtl/lphi_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lphi_pkg: shared types and constants of the linear probing hash table
// Field widths of the beats, the register reset value and the sequencer
// state encoding.
// ============================================================================
package lphi_pkg;

  localparam int HASH_W     = 64;
  localparam int POS_IN_W   = 40;
  localparam int IDX_W      = 12;
  localparam int CNT_W      = 13;
  localparam int SIZE_W     = 13;
  localparam int DIGIT_BITS = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_PROBE,
    ST_CHECK,
    ST_READ,
    ST_READ_DONE
  } lphi_state_t;

endpackage

// ----- hw/rtl/lphi_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lphi_if: request and response channels of the hash table
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ============================================================================
interface lphi_in_if import lphi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [HASH_W-1:0]   key_hash;
  logic [POS_IN_W-1:0] record_offset;
  logic [IDX_W-1:0]    slot_index;

  modport source (output valid, mode, key_hash, record_offset, slot_index,
                  input ready);
  modport sink   (input valid, mode, key_hash, record_offset, slot_index,
                  output ready);
endinterface

interface lphi_out_if import lphi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    placed_slot;
  logic [CNT_W-1:0]    probe_count;
  logic                table_full;
  logic [HASH_W-1:0]   read_hash;
  logic [POS_IN_W-1:0] read_position;
  logic                read_empty;

  modport source (output valid, placed_slot, probe_count, table_full, read_hash,
                  read_position, read_empty, input ready);
  modport sink   (input valid, placed_slot, probe_count, table_full, read_hash,
                  read_position, read_empty, output ready);
endinterface

// ----- hw/rtl/lphi_rem.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lphi_rem: iterative remainder unit
// Reduces a 64-bit hash modulo the table size, a few dividend bits per cycle.
// ============================================================================
module lphi_rem import lphi_pkg::*; #(
  parameter int DIV_W = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [DIV_W-1:0]  remainder
);

  localparam int STEPS = HASH_W / DIGIT_BITS;
  localparam int CW    = $clog2(STEPS);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [HASH_W-1:0] num;
  logic [DIV_W-1:0]  div;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  rem_next;

  // Restoring reduction of one digit: shift in a bit, subtract if it fits.
  always_comb begin
    logic [DIV_W:0]   t;
    logic [DIV_W-1:0] acc;
    acc = rem;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      t = {acc, num[HASH_W-1-i]};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
      acc = t[DIV_W-1:0];
    end
    rem_next = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      div <= divisor;
      rem <= '0;
    end else if (busy) begin
      num <= num << DIGIT_BITS;
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

// ----- hw/rtl/lphi_mem.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lphi_mem: slot storage
// One write port and one read port with registered read data.
// ============================================================================
module lphi_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 104
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/linear_probe_hash_insert.sv -----
`timescale 1ns / 1ps
// ============================================================================
// linear_probe_hash_insert: open-addressing hash table with linear probing
// Inserts (hash, position) entries into the first free slot at or after
// hash mod table_size, and reads back single slots.
// ============================================================================
// Usage:
//   in_ch carries one request per beat. Mode insert places key_hash and
//   record_offset; mode read returns the entry at slot_index.
//   out_ch carries exactly one response beat per request, in order.
//   cfg_wr_en/cfg_wr_data write table_size; write it only while idle.
// Sequencing:
//   A read passes ST_READ and then ST_READ_DONE, with the registered read
//   port of the slot memory between them; a slot beyond the storage is
//   answered from ST_READ. An insert waits in ST_MOD for the remainder unit,
//   which reduces the hash four bits per cycle, then alternates ST_PROBE and
//   ST_CHECK for every occupied slot passed; ST_CHECK of a free slot places
//   the entry, and ST_PROBE reports a full table. One request is in work at a time;
//   a new request beat can be taken the cycle after each response is loaded.
// Reset:
//   After reset the block sweeps all MAX_SLOTS slots to the empty pattern,
//   one per cycle, and holds in_ch.ready low until the sweep is done.
// Stalls:
//   The response sits in an output register. A new request is taken while
//   it waits; the next result waits in the sequencer until it drains.
// ============================================================================
module linear_probe_hash_insert import lphi_pkg::*; #(
  parameter int MAX_SLOTS     = 4096,
  parameter int POSITION_BITS = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  lphi_in_if.sink           in_ch,
  lphi_out_if.source        out_ch
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int SW = $clog2(MAX_SLOTS + 1);
  localparam int EW = HASH_W + POSITION_BITS;

  localparam logic [POSITION_BITS-1:0] POS_ONES   = '1;
  localparam logic [63:0]              POS_ONES_W = 64'(POS_ONES);

  // Configuration register.
  logic [SIZE_W-1:0] table_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      table_size <= cfg_wr_data;
    end
  end

  // Effective size: zero acts as one, anything above the storage is clamped.
  logic [31:0]   ts_w;
  logic [SW-1:0] size_eff;

  always_comb begin
    ts_w = 32'(table_size);
    if (ts_w == 32'd0) begin
      size_eff = SW'(1);
    end else if (ts_w > 32'(MAX_SLOTS)) begin
      size_eff = SW'(MAX_SLOTS);
    end else begin
      size_eff = SW'(ts_w);
    end
  end

  // Sequencer registers.
  lphi_state_t              state, state_next;
  logic [AW-1:0]            clr_cnt, clr_cnt_next;
  logic [AW-1:0]            cand, cand_next;
  logic [SW-1:0]            probes, probes_next;
  logic [SW-1:0]            size, size_next;
  logic                     oob, oob_next;
  logic [HASH_W-1:0]        hash_r;
  logic [POSITION_BITS-1:0] pos_r;

  // Request decode.
  logic                     in_accept;
  logic [31:0]              idx_w;
  logic                     idx_oob;
  logic [AW-1:0]            idx_trunc;
  logic [63:0]              pos_in_w;
  logic [POSITION_BITS-1:0] pos_in;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign idx_w       = 32'(in_ch.slot_index);
  assign idx_oob     = idx_w >= 32'(MAX_SLOTS);
  assign idx_trunc   = idx_w[AW-1:0];
  assign pos_in_w    = 64'(in_ch.record_offset);
  assign pos_in      = pos_in_w[POSITION_BITS-1:0];

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hash_r <= in_ch.key_hash;
      pos_r  <= pos_in;
    end
  end

  // Remainder unit: starts on the insert beat itself.
  logic          rem_start;
  logic          rem_done;
  logic [SW-1:0] rem_out;

  assign rem_start = in_accept && (in_ch.mode == MODE_INSERT);

  lphi_rem #(
    .DIV_W (SW)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (in_ch.key_hash),
    .divisor   (size_eff),
    .done      (rem_done),
    .remainder (rem_out)
  );

  // Slot memory. The read address is always the candidate register, so the
  // data of a slot shows up in the cycle after the candidate settles on it.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] rdata;

  lphi_mem #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cand),
    .rdata (rdata)
  );

  logic [HASH_W-1:0]        rd_hash;
  logic [POSITION_BITS-1:0] rd_pos;
  logic [63:0]              rd_pos_w;
  logic                     rd_empty;

  assign rd_hash  = rdata[EW-1:POSITION_BITS];
  assign rd_pos   = rdata[POSITION_BITS-1:0];
  assign rd_pos_w = 64'(rd_pos);
  assign rd_empty = &rdata;

  // Probe bookkeeping.
  logic [31:0]   cand_w;
  logic [31:0]   cand_inc;
  logic [AW-1:0] cand_wrap;
  logic [31:0]   probes_w;
  logic [31:0]   size_w;

  assign cand_w    = 32'(cand);
  assign cand_inc  = cand_w + 32'd1;
  assign size_w    = 32'(size);
  assign cand_wrap = (cand_inc >= size_w) ? '0 : cand_inc[AW-1:0];
  assign probes_w  = 32'(probes);

  // Output register handshake.
  logic                out_valid;
  logic                out_free;
  logic                out_load;
  logic [IDX_W-1:0]    res_placed;
  logic [CNT_W-1:0]    res_probes;
  logic                res_full;
  logic [HASH_W-1:0]   res_hash;
  logic [POS_IN_W-1:0] res_pos;
  logic                res_empty;

  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      cand    <= '0;
      probes  <= '0;
      size    <= '0;
      oob     <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      cand    <= cand_next;
      probes  <= probes_next;
      size    <= size_next;
      oob     <= oob_next;
    end
  end

  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    cand_next    = cand;
    probes_next  = probes;
    size_next    = size;
    oob_next     = oob;
    mem_we       = 1'b0;
    mem_waddr    = cand;
    mem_wdata    = {hash_r, pos_r};
    out_load     = 1'b0;
    res_placed   = '0;
    res_probes   = '0;
    res_full     = 1'b0;
    res_hash     = '0;
    res_pos      = '0;
    res_empty    = 1'b0;

    case (state)
      ST_CLEAR: begin
        // Sweep every slot to the empty pattern after reset.
        mem_we       = 1'b1;
        mem_waddr    = clr_cnt;
        mem_wdata    = '1;
        clr_cnt_next = clr_cnt + AW'(1);
        if (32'(clr_cnt) == 32'(MAX_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          size_next = size_eff;
          oob_next  = idx_oob;
          if (in_ch.mode == MODE_READ) begin
            cand_next  = idx_trunc;
            state_next = ST_READ;
          end else begin
            state_next = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        if (rem_done) begin
          cand_next   = rem_out[AW-1:0];
          probes_next = '0;
          state_next  = ST_PROBE;
        end
      end

      ST_PROBE: begin
        // Every slot in use has been passed: the table is full.
        if (probes == size) begin
          res_full   = 1'b1;
          res_probes = probes_w[CNT_W-1:0];
          if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (rd_empty) begin
          res_placed = cand_w[IDX_W-1:0];
          res_probes = probes_w[CNT_W-1:0];
          if (out_free) begin
            mem_we     = 1'b1;
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          probes_next = probes + SW'(1);
          cand_next   = cand_wrap;
          state_next  = ST_PROBE;
        end
      end

      ST_READ: begin
        // A slot beyond the storage reads as an empty entry.
        if (oob) begin
          res_hash  = '1;
          res_pos   = POS_ONES_W[POS_IN_W-1:0];
          res_empty = 1'b1;
          if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_READ_DONE;
        end
      end

      ST_READ_DONE: begin
        res_hash  = rd_hash;
        res_pos   = rd_pos_w[POS_IN_W-1:0];
        res_empty = rd_empty;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register.
  logic [IDX_W-1:0]    out_placed;
  logic [CNT_W-1:0]    out_probes;
  logic                out_full;
  logic [HASH_W-1:0]   out_hash;
  logic [POS_IN_W-1:0] out_pos;
  logic                out_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_placed <= res_placed;
      out_probes <= res_probes;
      out_full   <= res_full;
      out_hash   <= res_hash;
      out_pos    <= res_pos;
      out_empty  <= res_empty;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.placed_slot   = out_placed;
  assign out_ch.probe_count   = out_probes;
  assign out_ch.table_full    = out_full;
  assign out_ch.read_hash     = out_hash;
  assign out_ch.read_position = out_pos;
  assign out_ch.read_empty    = out_empty;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench: linear probing hash table, insert and slot read
// Drives request beats from a queue of pending items, predicts each response
// with a mirror of the slot table, and compares every response beat field by
// field. The run steps through several table sizes, fills small tables until
// they report full, and stalls both channels at random.
// ============================================================================
module testbench import lphi_pkg::*; ();

  localparam int SLOTS = 4096;
  localparam int POS_BITS = 40;
  // The response side stops taking beats for this long once, mid-run.
  localparam int LONG_HOLD = 600;
  localparam int HOLD_AT = 700;
  // Beats near the end of the run go with no idling on either side.
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYCLES = 50;
  // Reset, the clearing sweep after reset, the long hold, and some slack.
  localparam longint SETUP_CYCLES = 8 + SLOTS + LONG_HOLD + 2000;

  // One entry of the pending queue: either a request beat or a write of the
  // table size register, which waits until the block has gone idle.
  typedef struct packed {
    logic                is_size_write;
    logic [SIZE_W-1:0]   size;
    logic                mode;
    logic [HASH_W-1:0]   hash;
    logic [POS_IN_W-1:0] pos;
    logic [IDX_W-1:0]    idx;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0]    slot;
    logic [CNT_W-1:0]    probes;
    logic                full;
    logic [HASH_W-1:0]   rd_hash;
    logic [POS_IN_W-1:0] rd_pos;
    logic                rd_empty;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;

  // Local copies of the request and response handshake inputs; they are known
  // from time zero and feed the channel interfaces through assigns.
  logic                req_valid = 1'b0;
  logic                req_mode = MODE_INSERT;
  logic [HASH_W-1:0]   req_hash = '0;
  logic [POS_IN_W-1:0] req_pos = '0;
  logic [IDX_W-1:0]    req_idx = '0;
  logic                rsp_ready = 1'b0;

  lphi_in_if  req_ch ();
  lphi_out_if rsp_ch ();

  assign req_ch.valid         = req_valid;
  assign req_ch.mode          = req_mode;
  assign req_ch.key_hash      = req_hash;
  assign req_ch.record_offset = req_pos;
  assign req_ch.slot_index    = req_idx;
  assign rsp_ch.ready         = rsp_ready;

  linear_probe_hash_insert #(
    .MAX_SLOTS     (SLOTS),
    .POSITION_BITS (POS_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (req_ch),
    .out_ch      (rsp_ch)
  );

  always #5 clk = ~clk;

  // Mirror of the slot table and the size register, owned by the driver.
  logic [HASH_W-1:0]   mirror_hash [SLOTS];
  logic [POS_IN_W-1:0] mirror_pos [SLOTS];
  logic [SIZE_W-1:0]   mirror_size;

  request_t request_q [$];
  outcome_t outcome_q [$];
  request_t cur_req;

  int     item_total = 0;
  int     quiet_after = 0;
  int     accepted_count = 0;
  int     returned_count = 0;
  int     error_count = 0;
  int     gap_left = 0;
  int     stall_left = 0;
  int     hold_left = 0;
  logic   hold_done = 1'b0;
  int     req_idle_pct = 20;
  int     rsp_idle_pct = 20;
  longint cycle_count = 0;
  longint cycle_budget = 0;

  // Random phases mostly step the table size upward so that a phase can find
  // empty slots above the ones that earlier phases filled. The small tables
  // get enough inserts to run full; the later sizes of 3000 and 4095 shrink the table
  // back below entries that are already stored, which must no longer be probed.
  int phase_size [13] = '{2, 3, 7, 16, 31, 64, 100, 173, 256, 4096, 3000, 8191, 4095};
  int phase_len [13]  = '{11, 9, 14, 21, 30, 57, 62, 117, 132, 500, 250, 200, 120};

  // Works out the response to one request and applies its effect to the
  // mirror. An insert walks forward from hash mod size, wrapping at the size,
  // until it meets an all-ones entry or has passed span slots. Sizes of 0 and above SLOTS are clamped.
  function automatic outcome_t probe_outcome(request_t rq);
    outcome_t    res;
    int unsigned span;
    int unsigned spot;
    int unsigned probes;
    res = '0;
    if (rq.mode == MODE_READ) begin
      res.rd_hash  = mirror_hash[rq.idx];
      res.rd_pos   = mirror_pos[rq.idx];
      res.rd_empty = (&mirror_hash[rq.idx]) && (&mirror_pos[rq.idx]);
    end else begin
      if (mirror_size == 0) begin
        span = 1;
      end else if (mirror_size > SLOTS) begin
        span = SLOTS;
      end else begin
        span = mirror_size;
      end
      spot = 32'(rq.hash % 64'(span));
      probes = 0;
      while (probes < span && !((&mirror_hash[spot]) && (&mirror_pos[spot]))) begin
        probes++;
        spot = (spot + 1 == span) ? 0 : spot + 1;
      end
      if (probes == span) begin
        // Nothing free within the table size: refused, nothing stored.
        res.probes = CNT_W'(span);
        res.full   = 1'b1;
      end else begin
        // Storing the all-ones pattern leaves the slot looking empty.
        mirror_hash[spot] = rq.hash;
        mirror_pos[spot]  = rq.pos;
        res.slot   = IDX_W'(spot);
        res.probes = CNT_W'(probes);
      end
    end
    return res;
  endfunction

  task automatic queue_insert(input logic [HASH_W-1:0] h, input logic [POS_IN_W-1:0] p);
    request_t r;
    r = '0;
    r.mode = MODE_INSERT;
    r.hash = h;
    r.pos = p;
    request_q.push_back(r);
    item_total++;
  endtask

  task automatic queue_read(input logic [IDX_W-1:0] s);
    request_t r;
    r = '0;
    r.mode = MODE_READ;
    r.idx = s;
    request_q.push_back(r);
    item_total++;
  endtask

  task automatic queue_size_write(input logic [SIZE_W-1:0] v);
    request_t r;
    r = '0;
    r.is_size_write = 1'b1;
    r.size = v;
    request_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Request driver. A beat moves when req_valid and the block's ready are both
  // high at an edge; the prediction is made right then, so the mirror sees the
  // requests in exactly the order that the block takes them. Size writes wait
  // until every response has come back and nothing is on offer.
  always @(posedge clk) begin : request_driver
    logic     take_beat;
    logic     next_valid;
    logic     next_cfg;
    outcome_t outcome;
    request_t head;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        mirror_hash[i] = '1;
        mirror_pos[i] = '1;
      end
      mirror_size = SIZE_RESET;
      req_valid <= 1'b0;
      cfg_wr_en <= 1'b0;
    end else begin
      take_beat = req_valid && req_ch.ready;
      next_valid = req_valid && !take_beat;
      next_cfg = 1'b0;
      if (take_beat) begin
        outcome = probe_outcome(cur_req);
        outcome_q.push_back(outcome);
        accepted_count <= accepted_count + 1;
        // Allowance for this beat: the remainder unit, the ST_PROBE and ST_CHECK
        // states of every probed slot, the output path, and a full idle burst on each side.
        cycle_budget <= cycle_budget + 17 + 2 * (longint'(outcome.probes) + 1) + 60;
        if (accepted_count % 97 == 0) begin
          req_idle_pct = 20 * $urandom_range(0, 2);
        end
        if (accepted_count < quiet_after && $urandom_range(0, 99) < req_idle_pct) begin
          gap_left = $urandom_range(1, 17);
        end
      end
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (request_q.size() != 0) begin
          if (request_q[0].is_size_write) begin
            if (!take_beat && accepted_count == returned_count) begin
              head = request_q.pop_front();
              mirror_size = head.size;
              cfg_wr_data <= head.size;
              next_cfg = 1'b1;
            end
          end else begin
            cur_req = request_q.pop_front();
            req_mode <= cur_req.mode;
            req_hash <= cur_req.hash;
            req_pos <= cur_req.pos;
            req_idx <= cur_req.idx;
            next_valid = 1'b1;
          end
        end
      end
      req_valid <= next_valid;
      cfg_wr_en <= next_cfg;
    end
  end

  // Response monitor. Each response beat is matched against the oldest
  // prediction. Ready drops in random bursts, and once for a long hold so that
  // the block parks a result in its output register, takes one more request
  // and then has to stall its request channel.
  always @(posedge clk) begin : response_monitor
    outcome_t want;
    logic     next_ready;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_ready && rsp_ch.valid) begin
        if (outcome_q.size() == 0) begin
          $display("%0d ns: response beat with no request outstanding, expected none, actual slot 0x%0h",
                   $time, rsp_ch.placed_slot);
          error_count++;
        end else begin
          want = outcome_q.pop_front();
          check_field("placed_slot", 64'(want.slot), 64'(rsp_ch.placed_slot));
          check_field("probe_count", 64'(want.probes), 64'(rsp_ch.probe_count));
          check_field("table_full", 64'(want.full), 64'(rsp_ch.table_full));
          check_field("read_hash", want.rd_hash, rsp_ch.read_hash);
          check_field("read_position", 64'(want.rd_pos), 64'(rsp_ch.read_position));
          check_field("read_empty", 64'(want.rd_empty), 64'(rsp_ch.read_empty));
        end
        returned_count <= returned_count + 1;
        if (returned_count % 89 == 0) begin
          rsp_idle_pct = 20 * $urandom_range(0, 2);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!hold_done && returned_count == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        next_ready = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (returned_count < quiet_after && $urandom_range(0, 99) < rsp_idle_pct) begin
        stall_left = $urandom_range(1, 17) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      rsp_ready <= next_ready;
    end
  end

  // The limit grows with every accepted beat by what that beat may cost, so
  // a hang anywhere stops the run well after any correct run would be done.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4 * (SETUP_CYCLES + cycle_budget)) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : run_control
    logic [HASH_W-1:0]   h;
    logic [POS_IN_W-1:0] p;
    int                  pick;

    // Directed part at the reset size of 4096 slots. Empty slots read as all
    // ones, a hash of 4096 collides with slot 0, an all-ones hash lands on the
    // last slot and the next collision there wraps around past slots 0 and 1 to slot 2.
    queue_read(12'd0);
    queue_read(12'hfff);
    queue_insert(64'd0, 40'd0);
    queue_insert(64'd4096, 40'd1);
    queue_insert('1, 40'd12345);
    queue_insert(64'd4095, 40'hff_ffff_fffe);
    // The empty pattern itself: reported as placed, but the slot stays empty.
    queue_insert('1, '1);
    queue_read(12'd3);
    queue_insert(64'h8000_0000_0000_0000, 40'h80_0000_0000);
    queue_insert(64'h5555_5555_5555_5555, 40'haa_aaaa_aaaa);
    queue_insert(64'haaaa_aaaa_aaaa_aaaa, 40'h55_5555_5555);
    queue_read(12'h555);
    queue_read(12'haaa);
    queue_read(12'd0);
    queue_read(12'd1);
    queue_read(12'd2);
    // Shrink to one slot: slot 0 is taken, so inserts are refused, and the
    // entries above the size stay readable.
    queue_size_write(13'd1);
    queue_insert(64'd7, 40'd7);
    queue_insert('1, '1);
    // A size of zero behaves as one slot.
    queue_size_write(13'd0);
    queue_insert(64'hdead_beef_0123_4567, 40'h12_3456_789a);
    queue_read(12'hfff);
    // Sizes above the slot count are clamped to it.
    queue_size_write(13'h1fff);
    queue_insert(64'd4095, 40'h0f_0f0f_0f0f);
    queue_size_write(13'd5);
    queue_insert(64'd3, 40'd3);

    // Random part: a quarter reads of any slot, the rest inserts with random
    // content and occasional all-ones or tiny fields.
    for (int ph = 0; ph < 13; ph++) begin
      queue_size_write(SIZE_W'(phase_size[ph]));
      for (int n = 0; n < phase_len[ph]; n++) begin
        pick = $urandom_range(0, 31);
        if (pick < 8) begin
          queue_read(IDX_W'($urandom));
        end else begin
          h = {$urandom, $urandom};
          p = {8'($urandom), $urandom};
          if (pick == 8) begin
            h = '1;
            p = '1;
          end else if (pick == 9) begin
            h = '1;
          end else if (pick == 10) begin
            p = '1;
          end else if (pick == 11) begin
            h = 64'($urandom_range(0, 15));
          end else if (pick == 12) begin
            p = '0;
          end
          queue_insert(h, p);
        end
      end
    end
    quiet_after = item_total - QUIET_TAIL;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Every request produces exactly one response beat.
    wait (returned_count == item_total);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && outcome_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
